>>> rtl/core/hts_pkg.sv
// Shared types and constants for the height map triangle sampler.
package hts_pkg;

   localparam int HEIGHT_W     = 16;
   localparam int COORD_W      = 16;
   localparam int SAMPLE_IDX_W = 7;
   localparam int ADJ_W        = 17;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int DIM_REG_W    = 8;
   localparam int REQ_DATA_W   = 64;
   localparam int RSP_DATA_W   = 40;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic CMD_STORE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_COLUMNS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_ROWS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUT_LEVEL   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DROP_OFFSET = 2'd3;

   typedef enum logic [1:0] {
      OP_STORE,
      OP_SKIP,
      OP_SAMPLE,
      OP_MISS
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        step_col;
      logic        step_row;
      logic        x_major;
   } hts_ctrl_type;

endpackage

>>> rtl/core/hts_front.sv
// Front end: takes request words, bounds checks and splits them into cell and fraction.
module hts_front #(
   parameter int MAX_COLUMNS   = 128,
   parameter int MAX_ROWS      = 128,
   parameter int FRACTION_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hts_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   input  logic [$clog2(MAX_COLUMNS+1)-1:0]  cols,
   input  logic [$clog2(MAX_ROWS+1)-1:0]     rows,
   output logic                              out_valid,
   input  logic                              out_ready,
   output hts_pkg::hts_ctrl_type             out_ctrl,
   output logic [$clog2(MAX_COLUMNS)-1:0]    out_col,
   output logic [$clog2(MAX_ROWS)-1:0]       out_row,
   output logic [FRACTION_BITS-1:0]          out_fx,
   output logic [FRACTION_BITS-1:0]          out_fy,
   output logic [hts_pkg::HEIGHT_W-1:0]      out_height
);

   localparam int CIW = $clog2(MAX_COLUMNS);
   localparam int RIW = $clog2(MAX_ROWS);

   logic                           valid_ff;
   hts_pkg::hts_ctrl_type          ctrl_ff, ctrl_in;
   logic [CIW-1:0]                 col_ff, col_in;
   logic [RIW-1:0]                 row_ff, row_in;
   logic [FRACTION_BITS-1:0]       fx_ff, fx_in, fy_ff, fy_in;
   logic [hts_pkg::HEIGHT_W-1:0]   height_ff;

   logic [hts_pkg::COORD_W-1:0]    px, py;
   logic [31:0]                    px32, py32, ix32, iy32, wcol32, wrow32, cols32, rows32;
   logic                           take;

   assign take       = req_tvalid && req_tready;
   assign req_tready = !valid_ff || out_ready;

   assign px     = req_tdata[45:30];
   assign py     = req_tdata[61:46];
   assign px32   = 32'(px);
   assign py32   = 32'(py);
   assign ix32   = px32 >> FRACTION_BITS;
   assign iy32   = py32 >> FRACTION_BITS;
   assign wcol32 = 32'(req_tdata[6:0]);
   assign wrow32 = 32'(req_tdata[13:7]);
   assign cols32 = 32'(cols);
   assign rows32 = 32'(rows);
   assign fx_in  = px32[FRACTION_BITS-1:0];
   assign fy_in  = py32[FRACTION_BITS-1:0];

   always_comb begin
      ctrl_in.step_col = 1'b0;
      ctrl_in.step_row = 1'b0;
      ctrl_in.x_major  = (fx_in >= fy_in);
      if (req_tuser == hts_pkg::CMD_STORE) begin
         col_in = CIW'(wcol32);
         row_in = RIW'(wrow32);
         if (wcol32 < cols32 && wrow32 < rows32) begin
            ctrl_in.kind = hts_pkg::OP_STORE;
         end else begin
            ctrl_in.kind = hts_pkg::OP_SKIP;
         end
      end else begin
         col_in = CIW'(ix32);
         row_in = RIW'(iy32);
         ctrl_in.step_col = (ix32 + 32'd1) < cols32;
         ctrl_in.step_row = (iy32 + 32'd1) < rows32;
         if (!px[15] && !py[15] && ix32 < cols32 && iy32 < rows32) begin
            ctrl_in.kind = hts_pkg::OP_SAMPLE;
         end else begin
            ctrl_in.kind = hts_pkg::OP_MISS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ctrl_ff   <= ctrl_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         fx_ff     <= fx_in;
         fy_ff     <= fy_in;
         height_ff <= req_tdata[29:14];
      end
   end

   assign out_valid  = valid_ff;
   assign out_ctrl   = ctrl_ff;
   assign out_col    = col_ff;
   assign out_row    = row_ff;
   assign out_fx     = fx_ff;
   assign out_fy     = fy_ff;
   assign out_height = height_ff;

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> valid_ff)
      else $error("front stage empty after accepting a word");

endmodule

>>> rtl/core/hts_queue.sv
// Short FIFO between front end and back end.
module hts_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int DEPTH = hts_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue overfilled");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not drop on pop");

endmodule

>>> rtl/core/hts_back.sv
// Back end: address math, map store, triangle interpolation and cut-level adjust.
module hts_back #(
   parameter int MAX_COLUMNS   = 128,
   parameter int MAX_ROWS      = 128,
   parameter int FRACTION_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(MAX_COLUMNS+1)-1:0]  cols,
   input  logic [hts_pkg::HEIGHT_W-1:0]      cut_level,
   input  logic [hts_pkg::HEIGHT_W-1:0]      drop_offset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  hts_pkg::hts_ctrl_type             in_ctrl,
   input  logic [$clog2(MAX_COLUMNS)-1:0]    in_col,
   input  logic [$clog2(MAX_ROWS)-1:0]       in_row,
   input  logic [FRACTION_BITS-1:0]          in_fx,
   input  logic [FRACTION_BITS-1:0]          in_fy,
   input  logic [hts_pkg::HEIGHT_W-1:0]      in_height,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [hts_pkg::HEIGHT_W-1:0]      out_surface,
   output logic [hts_pkg::ADJ_W-1:0]         out_adjusted,
   output logic                              out_inside
);

   localparam int CCW   = $clog2(MAX_COLUMNS + 1);
   localparam int CIW   = $clog2(MAX_COLUMNS);
   localparam int RIW   = $clog2(MAX_ROWS);
   localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int HW    = hts_pkg::HEIGHT_W;
   localparam int DW    = HW + 1;
   localparam int PW    = DW + FRACTION_BITS + 1;
   localparam int SW    = PW + 1;

   logic adv;

   // stage 1: row bases
   logic                      v1_ff;
   hts_pkg::hts_ctrl_type     ctrl1_ff;
   logic [AW-1:0]             base0_ff, base1_ff;
   logic [CIW-1:0]            col1_ff;
   logic [FRACTION_BITS-1:0]  fx1_ff, fy1_ff;
   logic [HW-1:0]             height1_ff;
   logic [RIW:0]              row_next;
   logic [RIW+CCW-1:0]        prod0;
   logic [RIW+CCW:0]          prod1;

   // stage 2: map access
   logic                      v2_ff;
   hts_pkg::hts_ctrl_type     ctrl2_ff;
   logic [FRACTION_BITS-1:0]  fx2_ff, fy2_ff;
   logic [HW-1:0]             rd_a_ff, rd_b_ff, rd_c_ff, rd_d_ff;
   logic [AW-1:0]             addr_a, addr_b, addr_c, addr_d;
   logic                      map_we;
   logic [HW-1:0]             map_lo_mem [DEPTH];
   logic [HW-1:0]             map_hi_mem [DEPTH];

   // stage 3: edge differences
   logic                      v3_ff;
   hts_pkg::hts_ctrl_type     ctrl3_ff;
   logic [HW-1:0]             a3_ff;
   logic signed [DW-1:0]      d1_ff, d1_in, d2_ff, d2_in;
   logic [FRACTION_BITS-1:0]  w1_ff, w1_in, w2_ff, w2_in;

   // stage 4: products
   logic                      v4_ff;
   hts_pkg::hts_ctrl_type     ctrl4_ff;
   logic [HW-1:0]             a4_ff;
   logic signed [PW-1:0]      p1_ff, p2_ff;

   // output register
   logic                      out_valid_ff;
   logic [HW-1:0]             surface_ff, surface_in;
   logic [hts_pkg::ADJ_W-1:0] adjusted_ff, adjusted_in;
   logic                      inside_ff, inside_in;
   logic signed [SW-1:0]      sum;

   assign adv      = !out_valid_ff || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_valid_ff <= v4_ff;
      end
   end

   assign row_next = {1'b0, in_row} + (RIW+1)'(in_ctrl.step_row);
   assign prod0    = in_row * cols;
   assign prod1    = row_next * cols;

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl1_ff   <= in_ctrl;
         base0_ff   <= AW'(prod0);
         base1_ff   <= AW'(prod1);
         col1_ff    <= in_col;
         fx1_ff     <= in_fx;
         fy1_ff     <= in_fy;
         height1_ff <= in_height;
      end
   end

   assign addr_a = base0_ff + AW'(col1_ff);
   assign addr_c = addr_a + AW'(ctrl1_ff.step_col);
   assign addr_b = base1_ff + AW'(col1_ff);
   assign addr_d = addr_b + AW'(ctrl1_ff.step_col);
   assign map_we = adv && v1_ff && (ctrl1_ff.kind == hts_pkg::OP_STORE);

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_lo_mem[addr_a] <= height1_ff;
      end
      if (adv) begin
         rd_a_ff <= map_lo_mem[addr_a];
         rd_c_ff <= map_lo_mem[addr_c];
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_hi_mem[addr_a] <= height1_ff;
      end
      if (adv) begin
         rd_b_ff <= map_hi_mem[addr_b];
         rd_d_ff <= map_hi_mem[addr_d];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl2_ff <= ctrl1_ff;
         fx2_ff   <= fx1_ff;
         fy2_ff   <= fy1_ff;
      end
   end

   // S = A*one + (C-A)*fx + (D-C)*fy where fx >= fy, else A*one + (B-A)*fy + (D-B)*fx
   always_comb begin
      if (ctrl2_ff.x_major) begin
         d1_in = $signed({1'b0, rd_c_ff}) - $signed({1'b0, rd_a_ff});
         d2_in = $signed({1'b0, rd_d_ff}) - $signed({1'b0, rd_c_ff});
         w1_in = fx2_ff;
         w2_in = fy2_ff;
      end else begin
         d1_in = $signed({1'b0, rd_b_ff}) - $signed({1'b0, rd_a_ff});
         d2_in = $signed({1'b0, rd_d_ff}) - $signed({1'b0, rd_b_ff});
         w1_in = fy2_ff;
         w2_in = fx2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl3_ff <= ctrl2_ff;
         a3_ff    <= rd_a_ff;
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         w1_ff    <= w1_in;
         w2_ff    <= w2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl4_ff <= ctrl3_ff;
         a4_ff    <= a3_ff;
         p1_ff    <= PW'(d1_ff * $signed({1'b0, w1_ff}));
         p2_ff    <= PW'(d2_ff * $signed({1'b0, w2_ff}));
      end
   end

   assign sum = $signed({{(SW-HW){1'b0}}, a4_ff} << FRACTION_BITS) + SW'(p1_ff) + SW'(p2_ff);

   always_comb begin
      surface_in  = '0;
      inside_in   = 1'b0;
      adjusted_in = '0;
      if (ctrl4_ff.kind == hts_pkg::OP_SAMPLE) begin
         surface_in = sum[FRACTION_BITS +: HW];
         inside_in  = 1'b1;
      end
      if (ctrl4_ff.kind == hts_pkg::OP_SAMPLE || ctrl4_ff.kind == hts_pkg::OP_MISS) begin
         if (surface_in < cut_level) begin
            adjusted_in = {1'b0, surface_in} - {1'b0, drop_offset};
         end else begin
            adjusted_in = {1'b0, surface_in};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         surface_ff  <= surface_in;
         adjusted_ff <= adjusted_in;
         inside_ff   <= inside_in;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_surface  = surface_ff;
   assign out_adjusted = adjusted_ff;
   assign out_inside   = inside_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff}))
      else $error("back pipeline moved while output stalled");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !inside_ff) |-> surface_ff == '0)
      else $error("nonzero surface height outside the map");

endmodule

>>> rtl/core/heightmap_triangle_sampler.sv
// Top level of the height map triangle sampler: CSRs, front end, queue and back end.
//
//   group   dir   handshake              payload
//   req_    in    req_tvalid/req_tready  req_tdata (62 bits used), req_tuser = command
//   rsp_    out   rsp_tvalid/rsp_tready  rsp_tdata (33 bits used), rsp_tuser = inside_map
//   csr_    in    csr_we                 csr_index, csr_wdata
//
// One word per cycle in and out while rsp_tready stays high.
// The rate is set by the map access stage: two copies of the map, each with two read
// ports, serve the four cell corners in the same cycle, and two multipliers run side by side.
// Reset sets control state and CSRs only; the map holds garbage until written, no clearing pass.
// rsp_tready low freezes the back end; the 4-word queue and front stage then fill and
// req_tready drops.
module heightmap_triangle_sampler #(
   parameter int MAX_COLUMNS   = 128,
   parameter int MAX_ROWS      = 128,
   parameter int FRACTION_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // sample_column[6:0], sample_row[13:7], sample_height[29:14], point_x[45:30],
   // point_y[61:46], zero pad
   input  logic [hts_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // surface_height[15:0], adjusted_height[32:16], zero pad
   output logic [hts_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // inside_map
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [hts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CCW = $clog2(MAX_COLUMNS + 1);
   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int CIW = $clog2(MAX_COLUMNS);
   localparam int RIW = $clog2(MAX_ROWS);
   localparam int HW  = hts_pkg::HEIGHT_W;
   localparam int QW  = $bits(hts_pkg::hts_ctrl_type) + CIW + RIW + 2*FRACTION_BITS + HW;

   logic [hts_pkg::DIM_REG_W-1:0] map_columns_ff, map_rows_ff;
   logic [HW-1:0]                 cut_level_ff, drop_offset_ff;
   logic [31:0]                   cols32, rows32;
   logic [CCW-1:0]                cols;
   logic [RCW-1:0]                rows;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_columns_ff <= 8'd128;
         map_rows_ff    <= 8'd128;
         cut_level_ff   <= '0;
         drop_offset_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            hts_pkg::CSR_MAP_COLUMNS: map_columns_ff <= csr_wdata[7:0];
            hts_pkg::CSR_MAP_ROWS:    map_rows_ff    <= csr_wdata[7:0];
            hts_pkg::CSR_CUT_LEVEL:   cut_level_ff   <= csr_wdata;
            hts_pkg::CSR_DROP_OFFSET: drop_offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cols32 = 32'(map_columns_ff);
      rows32 = 32'(map_rows_ff);
      if (cols32 < 32'd2) begin
         cols32 = 32'd2;
      end else if (cols32 > 32'(MAX_COLUMNS)) begin
         cols32 = 32'(MAX_COLUMNS);
      end
      if (rows32 < 32'd2) begin
         rows32 = 32'd2;
      end else if (rows32 > 32'(MAX_ROWS)) begin
         rows32 = 32'(MAX_ROWS);
      end
   end

   assign cols = CCW'(cols32);
   assign rows = RCW'(rows32);

   logic                         f_valid, f_ready;
   hts_pkg::hts_ctrl_type        f_ctrl, q_ctrl;
   logic [CIW-1:0]               f_col, q_col;
   logic [RIW-1:0]               f_row, q_row;
   logic [FRACTION_BITS-1:0]     f_fx, f_fy, q_fx, q_fy;
   logic [HW-1:0]                f_height, q_height;
   logic                         q_valid, q_ready;
   logic [QW-1:0]                q_in, q_out;
   logic [HW-1:0]                surface;
   logic [hts_pkg::ADJ_W-1:0]    adjusted;

   hts_front #(
      .MAX_COLUMNS   (MAX_COLUMNS),
      .MAX_ROWS      (MAX_ROWS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cols       (cols),
      .rows       (rows),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .out_ctrl   (f_ctrl),
      .out_col    (f_col),
      .out_row    (f_row),
      .out_fx     (f_fx),
      .out_fy     (f_fy),
      .out_height (f_height)
   );

   assign q_in = {f_ctrl, f_col, f_row, f_fx, f_fy, f_height};

   hts_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (q_in),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_out)
   );

   assign {q_ctrl, q_col, q_row, q_fx, q_fy, q_height} = q_out;

   hts_back #(
      .MAX_COLUMNS   (MAX_COLUMNS),
      .MAX_ROWS      (MAX_ROWS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cols         (cols),
      .cut_level    (cut_level_ff),
      .drop_offset  (drop_offset_ff),
      .in_valid     (q_valid),
      .in_ready     (q_ready),
      .in_ctrl      (q_ctrl),
      .in_col       (q_col),
      .in_row       (q_row),
      .in_fx        (q_fx),
      .in_fy        (q_fy),
      .in_height    (q_height),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_surface  (surface),
      .out_adjusted (adjusted),
      .out_inside   (rsp_tuser)
   );

   assign rsp_tdata = {{(hts_pkg::RSP_DATA_W - hts_pkg::ADJ_W - HW){1'b0}}, adjusted, surface};

endmodule
